// File: hw/rtl/pcd_pkg.sv
package pcd_pkg;

  localparam int SampW = 16;
  localparam int AccW  = 40;
  localparam int ChanW = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIR,
    S_COMB,
    S_DONE
  } pcd_state_t;

  typedef struct packed {
    logic clear;
    logic rd;
    logic shift;
  } pcd_ctl_t;

  // clamp a 41-bit sum to the 40-bit accumulator range
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
    logic signed [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/polyphase_channel_decimator_core.sv
// flow: a tap load or a sample that does not close a group is simply stored; a group-closing
// sample starts a fir pass over the branch taps, then a combine pass over the DECIM branch
// outputs, and its result is then loaded into the output register
// no new tap or sample is accepted from a group-closing sample until its result is loaded,
// so input is also held off while a previous result is still held off at the output
// reset: rst clears control state and channel, then the tap and history memories are zeroed
module polyphase_channel_decimator_core import pcd_pkg::*; #(
  parameter int DECIM = 8,
  parameter int TAPS_PER_BRANCH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [55:0]   s_axis_tdata,  // tap_index, tap_value, sample_re, sample_im
  input  logic          s_axis_tuser,  // op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [79:0]   m_axis_tdata   // out_re, out_im
);

  localparam int AW = TAPS_PER_BRANCH > 1 ? $clog2(TAPS_PER_BRANCH) : 1;
  localparam int BW = DECIM > 1 ? $clog2(DECIM) : 1;
  localparam int CW = $clog2(TAPS_PER_BRANCH + DECIM + 8) + 1;

  pcd_state_t state, state_next;
  logic [ChanW-1:0] channel;
  logic [BW-1:0]    sc;
  logic [AW-1:0]    bwp;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    cnt;
  logic             clr_busy;
  logic [AW-1:0]    clr_addr;
  logic             accept;
  logic             last_smp;
  logic             k_ok;
  logic [7:0]       k;
  logic [BW-1:0]    tmod [256];
  logic [AW-1:0]    tdiv [256];
  pcd_ctl_t         ctl;
  logic             comb_v;
  logic signed [AccW-1:0] ch_re [DECIM+1];
  logic signed [AccW-1:0] ch_im [DECIM+1];
  logic signed [AccW-1:0] acc_re, acc_im;
  logic             load_out;

  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign tmod[g] = BW'(g % DECIM);
    assign tdiv[g] = AW'(g / DECIM);
  end

  assign k        = s_axis_tdata[7:0];
  assign k_ok     = 16'(k) < 16'(DECIM * TAPS_PER_BRANCH);
  assign s_axis_tready = (state == S_IDLE) && !clr_busy;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign last_smp = accept && s_axis_tuser && (sc == BW'(DECIM - 1));
  assign load_out = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    ctl.clear  = 1'b0;
    ctl.rd     = 1'b0;
    ctl.shift  = 1'b0;
    comb_v     = 1'b0;
    case (state)
      S_IDLE: begin
        ctl.clear = 1'b1;
        if (last_smp) state_next = S_FIR;
      end
      S_FIR: begin
        ctl.rd = cnt < CW'(TAPS_PER_BRANCH);
        if (cnt == CW'(TAPS_PER_BRANCH + 2)) state_next = S_COMB;
      end
      S_COMB: begin
        comb_v    = cnt < CW'(DECIM);
        ctl.shift = comb_v;
        if (cnt == CW'(DECIM + 2)) state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      channel <= '0;
      sc      <= '0;
      bwp     <= '0;
      cnt     <= '0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(TAPS_PER_BRANCH - 1)) clr_busy <= 1'b0;
      end
      if (cfg_we) channel <= cfg_data;
      if (accept && s_axis_tuser) begin
        sc <= last_smp ? '0 : sc + BW'(1);
      end
      if (last_smp) begin
        bwp <= (bwp == AW'(TAPS_PER_BRANCH - 1)) ? '0 : bwp + AW'(1);
      end
      cnt <= (state_next != state) ? '0 : cnt + CW'(1);
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_smp) begin
      pos <= bwp;
    end else if (ctl.rd) begin
      pos <= (pos == '0) ? AW'(TAPS_PER_BRANCH - 1) : pos - AW'(1);
    end
    if (load_out) begin
      m_axis_tdata <= {acc_im, acc_re};
    end
  end

  assign ch_re[DECIM] = '0;
  assign ch_im[DECIM] = '0;

  for (genvar i = 0; i < DECIM; i++) begin : g_cell
    pcd_cell #(.TAPS_PER_BRANCH(TAPS_PER_BRANCH)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .tap_addr(cnt[AW-1:0]), .hist_addr(pos),
      .tap_we(clr_busy || (accept && !s_axis_tuser && k_ok && (tmod[k] == BW'(i)))),
      .tap_waddr(clr_busy ? clr_addr : tdiv[k]),
      .tap_wdata(clr_busy ? 16'd0 : s_axis_tdata[23:8]),
      .hist_we(clr_busy || (accept && s_axis_tuser && (sc == BW'(DECIM - 1 - i)))),
      .hist_waddr(clr_busy ? clr_addr : bwp),
      .hist_wdata(clr_busy ? 32'd0 : {s_axis_tdata[55:40], s_axis_tdata[39:24]}),
      .y_re_in(ch_re[i+1]), .y_im_in(ch_im[i+1]),
      .y_re(ch_re[i]), .y_im(ch_im[i])
    );
  end

  pcd_comb #(.DECIM(DECIM)) u_comb (
    .clk(clk), .rst(rst), .clear(state == S_FIR), .in_v(comb_v),
    .channel(channel), .y_re(ch_re[0]), .y_im(ch_im[0]),
    .acc_re(acc_re), .acc_im(acc_im)
  );

`ifndef SYNTHESIS
  a_sc_range: assert property (@(posedge clk) disable iff (rst)
    sc <= BW'(DECIM - 1)) else $error("stream counter out of range");
  a_bwp_range: assert property (@(posedge clk) disable iff (rst)
    bwp <= AW'(TAPS_PER_BRANCH - 1)) else $error("write pointer out of range");
  a_group_start: assert property (@(posedge clk) disable iff (rst)
    last_smp |=> state == S_FIR) else $error("group did not start filtering");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_axis_tvalid && state == S_IDLE) else $error("result not presented");
`endif

endmodule

// File: hw/rtl/pcd_ram.sv
module pcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pcd_cell.sv
module pcd_cell import pcd_pkg::*; #(
  parameter int TAPS_PER_BRANCH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pcd_ctl_t                             ctl,
  input  logic [(TAPS_PER_BRANCH > 1 ? $clog2(TAPS_PER_BRANCH) : 1)-1:0] tap_addr,
  input  logic [(TAPS_PER_BRANCH > 1 ? $clog2(TAPS_PER_BRANCH) : 1)-1:0] hist_addr,
  input  logic                                 tap_we,
  input  logic [(TAPS_PER_BRANCH > 1 ? $clog2(TAPS_PER_BRANCH) : 1)-1:0] tap_waddr,
  input  logic signed [SampW-1:0]              tap_wdata,
  input  logic                                 hist_we,
  input  logic [(TAPS_PER_BRANCH > 1 ? $clog2(TAPS_PER_BRANCH) : 1)-1:0] hist_waddr,
  input  logic [2*SampW-1:0]                   hist_wdata,
  input  logic signed [AccW-1:0]               y_re_in,
  input  logic signed [AccW-1:0]               y_im_in,
  output logic signed [AccW-1:0]               y_re,
  output logic signed [AccW-1:0]               y_im
);

  logic [SampW-1:0]       h;
  logic [2*SampW-1:0]     x;
  logic                   rd_q;
  logic                   prod_v;
  logic signed [2*SampW-1:0] prod_re;
  logic signed [2*SampW-1:0] prod_im;

  pcd_ram #(.WIDTH(SampW), .DEPTH(TAPS_PER_BRANCH)) u_taps (
    .clk(clk), .we(tap_we), .waddr(tap_waddr), .wdata(tap_wdata),
    .raddr(tap_addr), .rdata(h)
  );

  pcd_ram #(.WIDTH(2*SampW), .DEPTH(TAPS_PER_BRANCH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_addr), .rdata(x)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_q   <= ctl.rd;
      prod_v <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    prod_re <= $signed(h) * $signed(x[SampW-1:0]);
    prod_im <= $signed(h) * $signed(x[2*SampW-1:SampW]);
    if (ctl.clear) begin
      y_re <= '0;
      y_im <= '0;
    end else if (prod_v) begin
      y_re <= sat_acc({y_re[AccW-1], y_re} + (AccW+1)'(prod_re));
      y_im <= sat_acc({y_im[AccW-1], y_im} + (AccW+1)'(prod_im));
    end else if (ctl.shift) begin
      y_re <= y_re_in;
      y_im <= y_im_in;
    end
  end

endmodule

// File: hw/rtl/pcd_comb.sv
module pcd_comb import pcd_pkg::*; #(
  parameter int DECIM = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   in_v,
  input  logic [ChanW-1:0]       channel,
  input  logic signed [AccW-1:0] y_re,
  input  logic signed [AccW-1:0] y_im,
  output logic signed [AccW-1:0] acc_re,
  output logic signed [AccW-1:0] acc_im
);

  localparam int BW = DECIM > 1 ? $clog2(DECIM) : 1;
  localparam int PW = AccW + SampW;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;

  function automatic logic [31:0] twid(input int m);
    logic [63:0] q, r, x, x2, t, sub, v, sv, cv;
    logic [15:0] s16, c16, wr, wi;
    q = 64'((4 * m) / DECIM);
    r = 64'((4 * m) % DECIM);
    x = (HalfPiQ30 * r + 64'(DECIM / 2)) / 64'(DECIM);
    x2 = (x * x) >> 30;
    t = OneQ30;
    sub = ((x2 * t) >> 30) / 64'd110; t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd72;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd42;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd20;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd6;   t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    v = (x * t) >> 30;
    sv = (v + 64'd16384) >> 15;
    s16 = sv > 64'd32767 ? 16'd32767 : sv[15:0];
    t = OneQ30;
    sub = ((x2 * t) >> 30) / 64'd132; t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd90;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd56;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd30;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd12;  t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 64'd2;   t = sub >= OneQ30 ? 64'd0 : OneQ30 - sub;
    cv = (t + 64'd16384) >> 15;
    c16 = cv > 64'd32767 ? 16'd32767 : cv[15:0];
    case (q[1:0])
      2'd0: begin wr = c16;  wi = s16;  end
      2'd1: begin wr = -s16; wi = c16;  end
      2'd2: begin wr = -c16; wi = -s16; end
      default: begin wr = s16; wi = -c16; end
    endcase
    return {wr, wi};
  endfunction

  logic [15:0]  w_re_tab [DECIM];
  logic [15:0]  w_im_tab [DECIM];
  logic [BW-1:0] chan_mod [8];

  for (genvar g = 0; g < DECIM; g++) begin : g_tw
    localparam logic [31:0] W = twid(g);
    assign w_re_tab[g] = W[31:16];
    assign w_im_tab[g] = W[15:0];
  end

  for (genvar c = 0; c < 8; c++) begin : g_cm
    assign chan_mod[c] = BW'(c % DECIM);
  end

  logic [BW-1:0] m;
  logic [BW:0]   m_sum;
  logic          v1, v2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [PW:0]   s_re, s_im;
  logic signed [PW-15:0] sh_re, sh_im;
  logic signed [AccW-1:0] t_re, t_im;

  assign m_sum = {1'b0, m} + {1'b0, chan_mod[channel]};

  function automatic logic signed [AccW-1:0] sat_term(input logic signed [PW-15:0] v);
    logic signed [AccW-1:0] r;
    if (v[PW-15:AccW-1] != {(PW-14-AccW+1){v[PW-15]}}) begin
      r = v[PW-15] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

  assign s_re  = (PW+1)'(p_rr) - (PW+1)'(p_ii) + (PW+1)'(16384);
  assign s_im  = (PW+1)'(p_ri) + (PW+1)'(p_ir) + (PW+1)'(16384);
  assign sh_re = s_re[PW:15];
  assign sh_im = s_im[PW:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m  <= '0;
    end else begin
      v1 <= in_v;
      v2 <= v1;
      if (clear) begin
        m <= '0;
      end else if (in_v) begin
        m <= m_sum >= (BW+1)'(DECIM) ? BW'(m_sum - (BW+1)'(DECIM)) : m_sum[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_rr <= y_re * $signed(w_re_tab[m]);
    p_ii <= y_im * $signed(w_im_tab[m]);
    p_ri <= y_re * $signed(w_im_tab[m]);
    p_ir <= y_im * $signed(w_re_tab[m]);
    t_re <= sat_term(sh_re);
    t_im <= sat_term(sh_im);
    if (clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= sat_acc({acc_re[AccW-1], acc_re} + {t_re[AccW-1], t_re});
      acc_im <= sat_acc({acc_im[AccW-1], acc_im} + {t_im[AccW-1], t_im});
    end
  end

endmodule
